// ===== design/rpa_pkg.sv =====
// Package with the types, constants and codes shared by the page allocator files.
package rpa_pkg;

    localparam int NUM_PAGES  = 32768;
    localparam int COUNT_BITS = 8;

    localparam int PAGE_W      = 15;
    localparam int END_W       = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 8;

    localparam int PAGE_LIMIT = (NUM_PAGES < 32768) ? NUM_PAGES : 32768;
    localparam int STACK_CAP  = (NUM_PAGES < 65535) ? NUM_PAGES : 65535;

    localparam int CNT_AW   = $clog2(PAGE_LIMIT);
    localparam int STK_AW   = $clog2(STACK_CAP);
    localparam int DEPTH_W  = $clog2(STACK_CAP + 1);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_SHARE  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_UNREF     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef enum logic {
        CFG_FIRST_PAGE = 1'b0,
        CFG_END_PAGE   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_STACK,
        S_COUNT
    } state_t;

endpackage

// ===== design/rpa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/refcounted_page_allocator_top.sv =====
// Top level of the reference-counted page allocator.
//
// Requests (allocate, free, share) enter on the s_ stream and each gives one result item on the
// m_ stream. Reference counts live in a synchronous RAM with one entry per page and returned
// pages in a second RAM used as a stack. After reset a clearing pass writes every count to zero,
// one entry a cycle; no request is taken until it ends, while configuration writes are taken
// at any time. For free, share and the unused code the count RAM read is issued as the request
// is taken, and the count is written back and the result registered in the S_COUNT state. An
// allocate served from the fresh-page pointer follows the same steps; one served from the stack
// of returned pages passes through S_STACK first, as the stack RAM read comes before the count
// read. A request is taken while an earlier result still waits, and waits in S_COUNT
// until the output register is free.
module refcounted_page_allocator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // fields from bit 0: operation[1:0], page[16:2], zero padding
    input  logic [rpa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fields from bit 0: status[2:0], page_out[17:3], count_after[25:18], released[26], padding
    output logic [rpa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [rpa_pkg::END_W-1:0]       cfg_data
);

    localparam int CNT_W = rpa_pkg::COUNT_BITS;

    rpa_pkg::state_t                  state_reg, state_next;
    logic [rpa_pkg::CNT_AW-1:0]       clr_reg;
    logic [rpa_pkg::PAGE_W-1:0]       first_reg;
    logic [rpa_pkg::END_W-1:0]        end_reg;
    logic [rpa_pkg::END_W-1:0]        fresh_reg, fresh_next;
    logic [rpa_pkg::DEPTH_W-1:0]      depth_reg, depth_next;
    rpa_pkg::op_t                     op_reg;
    logic [rpa_pkg::PAGE_W-1:0]       page_reg;
    logic [rpa_pkg::CNT_AW-1:0]       addr_reg, addr_next;
    logic                             got_reg, got_next;

    logic                             m_valid_reg;
    rpa_pkg::status_t                 status_reg;
    logic [rpa_pkg::PAGE_W-1:0]       pout_reg;
    logic [rpa_pkg::COUNT_OUT_W-1:0]  cnt_out_reg;
    logic                             rel_reg;

    logic                             s_accept;
    rpa_pkg::op_t                     s_op;
    logic [rpa_pkg::PAGE_W-1:0]       s_page;
    logic                             fresh_ok;
    logic                             out_free;
    logic                             go;
    logic                             in_range;

    logic                             cnt_we;
    logic [rpa_pkg::CNT_AW-1:0]       cnt_waddr;
    logic [CNT_W-1:0]                 cnt_wdata;
    logic [CNT_W-1:0]                 cnt_rdata;
    logic                             stk_we;
    logic [rpa_pkg::STK_AW-1:0]       stk_raddr;
    logic [rpa_pkg::PAGE_W-1:0]       stk_rdata;

    logic                             upd_we;
    logic [CNT_W-1:0]                 upd_cnt;
    logic                             push;
    rpa_pkg::status_t                 res_status;
    logic [rpa_pkg::PAGE_W-1:0]       res_pout;
    logic [CNT_W-1:0]                 res_cnt;
    logic                             res_rel;
    logic                             pop;

    assign s_op     = rpa_pkg::op_t'(s_tdata[1:0]);
    assign s_page   = s_tdata[16:2];
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == rpa_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign fresh_ok = (fresh_reg > {1'b0, first_reg}) && (fresh_reg != '0);
    assign out_free = !m_valid_reg || m_tready;
    assign go       = (state_reg == rpa_pkg::S_COUNT) && out_free;
    assign in_range = ({1'b0, page_reg} >= {1'b0, first_reg})
                   && ({1'b0, page_reg} < end_reg)
                   && (32'(page_reg) < rpa_pkg::PAGE_LIMIT);
    assign pop      = s_accept && (s_op == rpa_pkg::OP_ALLOC) && (depth_reg != '0);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, rel_reg, cnt_out_reg, pout_reg, status_reg};

    assign stk_raddr = rpa_pkg::STK_AW'(depth_reg - 1'b1);

    rpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (rpa_pkg::PAGE_LIMIT)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (addr_next),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (rpa_pkg::PAGE_W),
        .DEPTH (rpa_pkg::STACK_CAP)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (rpa_pkg::STK_AW'(depth_reg)),
        .wdata (page_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpa_pkg::S_CLEAR: begin
                if (clr_reg == rpa_pkg::CNT_AW'(rpa_pkg::PAGE_LIMIT - 1)) begin
                    state_next = rpa_pkg::S_IDLE;
                end
            end
            rpa_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = pop ? rpa_pkg::S_STACK : rpa_pkg::S_COUNT;
                end
            end
            rpa_pkg::S_STACK: begin
                state_next = rpa_pkg::S_COUNT;
            end
            rpa_pkg::S_COUNT: begin
                if (out_free) begin
                    state_next = rpa_pkg::S_IDLE;
                end
            end
            default: state_next = rpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        addr_next = addr_reg;
        got_next  = got_reg;
        unique case (state_reg)
            rpa_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_op == rpa_pkg::OP_ALLOC) begin
                        got_next = pop || fresh_ok;
                        if (!pop && fresh_ok) begin
                            addr_next = rpa_pkg::CNT_AW'(fresh_reg - 1'b1);
                        end
                    end else begin
                        addr_next = rpa_pkg::CNT_AW'(s_page);
                    end
                end
            end
            rpa_pkg::S_STACK: begin
                addr_next = rpa_pkg::CNT_AW'(stk_rdata);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        upd_we     = 1'b0;
        upd_cnt    = cnt_rdata;
        push       = 1'b0;
        res_status = rpa_pkg::ST_OK;
        res_pout   = page_reg;
        res_cnt    = '0;
        res_rel    = 1'b0;
        unique case (op_reg)
            rpa_pkg::OP_ALLOC: begin
                res_pout = rpa_pkg::PAGE_W'(addr_reg);
                if (!got_reg) begin
                    res_status = rpa_pkg::ST_EMPTY;
                    res_pout   = '0;
                end else if (cnt_rdata == '1) begin
                    res_status = rpa_pkg::ST_SATURATED;
                    res_cnt    = cnt_rdata;
                end else begin
                    upd_we  = 1'b1;
                    upd_cnt = cnt_rdata + 1'b1;
                    res_cnt = upd_cnt;
                end
            end
            rpa_pkg::OP_FREE: begin
                if (!in_range) begin
                    res_status = rpa_pkg::ST_RANGE;
                end else if (cnt_rdata == '0) begin
                    res_status = rpa_pkg::ST_UNREF;
                end else begin
                    upd_we  = 1'b1;
                    upd_cnt = cnt_rdata - 1'b1;
                    res_cnt = upd_cnt;
                    if (upd_cnt == '0 && 32'(depth_reg) < rpa_pkg::STACK_CAP) begin
                        push    = 1'b1;
                        res_rel = 1'b1;
                    end
                end
            end
            rpa_pkg::OP_SHARE: begin
                if (!in_range) begin
                    res_status = rpa_pkg::ST_RANGE;
                end else if (cnt_rdata == '1) begin
                    res_status = rpa_pkg::ST_SATURATED;
                    res_cnt    = cnt_rdata;
                end else begin
                    upd_we  = 1'b1;
                    upd_cnt = cnt_rdata + 1'b1;
                    res_cnt = upd_cnt;
                end
            end
            rpa_pkg::OP_UNUSED: begin
                if (in_range) begin
                    res_cnt = cnt_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = addr_reg;
        cnt_wdata = upd_cnt;
        stk_we    = 1'b0;
        if (state_reg == rpa_pkg::S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            cnt_wdata = '0;
        end else if (go) begin
            cnt_we = upd_we;
            stk_we = push;
        end
    end

    always_comb begin
        depth_next = depth_reg;
        if (pop) begin
            depth_next = depth_reg - 1'b1;
        end else if (go && push) begin
            depth_next = depth_reg + 1'b1;
        end
    end

    always_comb begin
        fresh_next = fresh_reg;
        if (cfg_valid && cfg_ready && cfg_index == rpa_pkg::CFG_END_PAGE) begin
            if (32'(cfg_data) > rpa_pkg::PAGE_LIMIT) begin
                fresh_next = rpa_pkg::END_W'(rpa_pkg::PAGE_LIMIT);
            end else begin
                fresh_next = cfg_data;
            end
        end else if (s_accept && s_op == rpa_pkg::OP_ALLOC && !pop && fresh_ok) begin
            fresh_next = fresh_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpa_pkg::S_CLEAR;
            clr_reg     <= '0;
            first_reg   <= '0;
            end_reg     <= rpa_pkg::END_W'(32768);
            fresh_reg   <= rpa_pkg::END_W'(rpa_pkg::PAGE_LIMIT);
            depth_reg   <= '0;
            got_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fresh_reg <= fresh_next;
            depth_reg <= depth_next;
            got_reg   <= got_next;
            if (state_reg == rpa_pkg::S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rpa_pkg::CFG_FIRST_PAGE) begin
                    first_reg <= cfg_data[rpa_pkg::PAGE_W-1:0];
                end else begin
                    end_reg <= cfg_data;
                end
            end
            if (go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        if (s_accept) begin
            op_reg   <= s_op;
            page_reg <= s_page;
        end
        if (go) begin
            status_reg  <= res_status;
            pout_reg    <= res_pout;
            cnt_out_reg <= rpa_pkg::COUNT_OUT_W'(res_cnt);
            rel_reg     <= res_rel;
        end
    end

    a_clear_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rpa_pkg::S_CLEAR |-> !m_valid_reg)
        else $error("A result was presented during the clearing pass.");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= rpa_pkg::STACK_CAP)
        else $error("The returned-page stack exceeded its capacity.");

    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fresh_reg) <= rpa_pkg::PAGE_LIMIT)
        else $error("The fresh-page pointer left the page range.");

    a_release_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        go && res_rel |-> res_status == rpa_pkg::ST_OK && res_cnt == '0)
        else $error("A page was pooled without its count reaching zero.");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == rpa_pkg::S_STACK || state_reg == rpa_pkg::S_COUNT)
        else $error("An accepted item did not start its memory access.");

endmodule

// ===== bench/refcounted_page_allocator_top_test.sv =====
// Self-checking testbench for the reference-counted page allocator, with directed and random items.
module refcounted_page_allocator_top_test;
    import rpa_pkg::*;

    typedef struct packed {
        status_t                 status;
        logic [PAGE_W-1:0]       page;
        logic [COUNT_OUT_W-1:0]  count;
        logic                    released;
    } alloc_result_t;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        cfg_index_t    reg_sel;
        bit [15:0]     value;
        op_t           op;
        alloc_result_t result;
    } directed_row_t;

    typedef struct packed {
        bit [14:0] base;
        bit [15:0] limit;
        bit [10:0] items;
        bit [6:0]  alloc_pct;
        bit [6:0]  free_pct;
        bit [6:0]  share_pct;
    } phase_plan_t;

    localparam alloc_result_t NO_RESULT = '{ST_OK, 15'd0, 8'd0, 1'b0};
    localparam int NUM_ROWS = 37;
    localparam int NUM_PHASES = 9;

    localparam directed_row_t DIRECTED_PLAN [0:NUM_ROWS-1] = '{
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd32767, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd32766, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd32767, OP_FREE, '{ST_OK, 15'd32767, 8'd0, 1'b1}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd32767, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd32767, OP_SHARE, '{ST_OK, 15'd32767, 8'd2, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_FREE, '{ST_UNREF, 15'd0, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd32767, OP_UNUSED, '{ST_OK, 15'd32767, 8'd2, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_UNUSED, '{ST_OK, 15'd0, 8'd0, 1'b0}},
        '{ROW_CFG, CFG_FIRST_PAGE, 16'd100, OP_ALLOC, NO_RESULT},
        '{ROW_CFG, CFG_END_PAGE, 16'd103, OP_ALLOC, NO_RESULT},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd99, OP_FREE, '{ST_RANGE, 15'd99, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd103, OP_SHARE, '{ST_RANGE, 15'd103, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd32767, OP_SHARE, '{ST_RANGE, 15'd32767, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd102, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd101, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd100, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_EMPTY, 15'd0, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd100, OP_FREE, '{ST_OK, 15'd100, 8'd0, 1'b1}},
        '{ROW_CFG, CFG_FIRST_PAGE, 16'd200, OP_ALLOC, NO_RESULT},
        '{ROW_CFG, CFG_END_PAGE, 16'd205, OP_ALLOC, NO_RESULT},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd100, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd100, OP_UNUSED, '{ST_OK, 15'd100, 8'd0, 1'b0}},
        '{ROW_CFG, CFG_FIRST_PAGE, 16'd300, OP_ALLOC, NO_RESULT},
        '{ROW_CFG, CFG_END_PAGE, 16'd10, OP_ALLOC, NO_RESULT},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_EMPTY, 15'd0, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd5, OP_SHARE, '{ST_RANGE, 15'd5, 8'd0, 1'b0}},
        '{ROW_CFG, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, NO_RESULT},
        '{ROW_CFG, CFG_END_PAGE, 16'd0, OP_ALLOC, NO_RESULT},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_EMPTY, 15'd0, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_FREE, '{ST_RANGE, 15'd0, 8'd0, 1'b0}},
        '{ROW_CFG, CFG_END_PAGE, 16'd1, OP_ALLOC, NO_RESULT},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd0, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_SHARE, '{ST_OK, 15'd0, 8'd2, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_FREE, '{ST_OK, 15'd0, 8'd1, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_FREE, '{ST_OK, 15'd0, 8'd0, 1'b1}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_FREE, '{ST_UNREF, 15'd0, 8'd0, 1'b0}},
        '{ROW_REQ, CFG_FIRST_PAGE, 16'd0, OP_ALLOC, '{ST_OK, 15'd0, 8'd1, 1'b0}}
    };

    // The two phases on page 32767 alone first drive that page to saturation and then allocate it.
    localparam phase_plan_t PHASES [0:NUM_PHASES-1] = '{
        '{15'd0, 16'd32768, 11'd300, 7'd35, 7'd35, 7'd25},
        '{15'd10, 16'd14, 11'd250, 7'd30, 7'd35, 7'd30},
        '{15'd32767, 16'd32768, 11'd350, 7'd10, 7'd5, 7'd80},
        '{15'd32767, 16'd32768, 11'd150, 7'd60, 7'd20, 7'd15},
        '{15'd300, 16'd10, 11'd100, 7'd30, 7'd30, 7'd30},
        '{15'd0, 16'd1, 11'd150, 7'd35, 7'd35, 7'd25},
        '{15'd5000, 16'd5003, 11'd250, 7'd35, 7'd35, 7'd25},
        '{15'd0, 16'd0, 11'd100, 7'd40, 7'd30, 7'd25},
        '{15'd0, 16'd0, 11'd250, 7'd35, 7'd35, 7'd25}
    };

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_index = 1'b0;
    logic [END_W-1:0]        cfg_data = '0;

    bit [COUNT_OUT_W-1:0]    page_refs [0:NUM_PAGES-1];
    bit [PAGE_W-1:0]         pool_stack [$];
    bit [PAGE_W-1:0]         handed_pages [$];
    bit [END_W-1:0]          fresh_top = 16'd32768;
    bit [PAGE_W-1:0]         first_cfg = '0;
    bit [END_W-1:0]          end_cfg = 16'd32768;
    alloc_result_t           pending_results [$];
    int unsigned             error_count = 0;
    int unsigned             send_idle_pct = 0;
    int unsigned             recv_stall_pct = 0;

    refcounted_page_allocator_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic bit page_managed(bit [PAGE_W-1:0] pg);
        return pg >= first_cfg && {1'b0, pg} < end_cfg;
    endfunction

    function automatic alloc_result_t predict_request(op_t op, bit [PAGE_W-1:0] pg);
        alloc_result_t r;
        bit            got;
        r = '{ST_OK, pg, 8'd0, 1'b0};
        got = 1'b0;
        case (op)
            OP_ALLOC: begin
                if (pool_stack.size() > 0) begin
                    r.page = pool_stack.pop_back();
                    got = 1'b1;
                end else if (fresh_top > first_cfg && fresh_top > 0) begin
                    fresh_top--;
                    r.page = fresh_top[PAGE_W-1:0];
                    got = 1'b1;
                end
                if (!got) begin
                    r.status = ST_EMPTY;
                    r.page = '0;
                end else if (page_refs[r.page] == 8'hFF) begin
                    r.status = ST_SATURATED;
                    r.count = 8'hFF;
                end else begin
                    page_refs[r.page]++;
                    r.count = page_refs[r.page];
                end
                if (got) begin
                    handed_pages.push_back(r.page);
                    if (handed_pages.size() > 16) void'(handed_pages.pop_front());
                end
            end
            OP_FREE: begin
                if (!page_managed(pg)) begin
                    r.status = ST_RANGE;
                end else if (page_refs[pg] == 0) begin
                    r.status = ST_UNREF;
                end else begin
                    page_refs[pg]--;
                    r.count = page_refs[pg];
                    if (r.count == 0 && pool_stack.size() < STACK_CAP) begin
                        pool_stack.push_back(pg);
                        r.released = 1'b1;
                    end
                end
            end
            OP_SHARE: begin
                if (!page_managed(pg)) begin
                    r.status = ST_RANGE;
                end else if (page_refs[pg] == 8'hFF) begin
                    r.status = ST_SATURATED;
                    r.count = 8'hFF;
                end else begin
                    page_refs[pg]++;
                    r.count = page_refs[pg];
                end
            end
            default: begin
                if (page_managed(pg)) r.count = page_refs[pg];
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic bit [PAGE_W-1:0] pick_page();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && handed_pages.size() > 0)
            return handed_pages[$urandom_range(0, handed_pages.size() - 1)];
        if (roll < 85 && end_cfg > first_cfg)
            return PAGE_W'(first_cfg + $urandom_range(0, end_cfg - first_cfg - 1));
        return PAGE_W'($urandom_range(0, 32767));
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(cfg_index_t sel, bit [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (sel == CFG_FIRST_PAGE) begin
            first_cfg = value[PAGE_W-1:0];
        end else begin
            end_cfg = value;
            fresh_top = END_W'((value < PAGE_LIMIT) ? value : PAGE_LIMIT);
        end
    endtask

    task automatic send_request(op_t op, bit [PAGE_W-1:0] pg, bit typed,
                                alloc_result_t typed_result);
        alloc_result_t predicted;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, pg, op};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = predict_request(op, pg);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid === 1'b1 && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
                    check_field("page_out", 32'(want.page), 32'(m_tdata[17:3]));
                    check_field("count_after", 32'(want.count), 32'(m_tdata[25:18]));
                    check_field("released", 32'(want.released), 32'(m_tdata[26]));
                end
            end
        end
    end

    initial begin
        phase_plan_t   plan;
        int unsigned   roll;
        op_t           op;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ROW_CFG)
                write_register(DIRECTED_PLAN[i].reg_sel, DIRECTED_PLAN[i].value);
            else
                send_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].value[PAGE_W-1:0], 1'b1,
                             DIRECTED_PLAN[i].result);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            plan = PHASES[ph];
            if (ph == NUM_PHASES - 1) begin
                plan.base = 15'($urandom_range(0, 32760));
                plan.limit = 16'(plan.base + $urandom_range(1, 6));
            end
            write_register(CFG_FIRST_PAGE, {1'b0, plan.base});
            write_register(CFG_END_PAGE, plan.limit);
            send_idle_pct = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 12 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 12 : 0;
            repeat (plan.items) begin
                roll = $urandom_range(0, 99);
                if (roll < plan.alloc_pct)
                    op = OP_ALLOC;
                else if (roll < plan.alloc_pct + plan.free_pct)
                    op = OP_FREE;
                else if (roll < plan.alloc_pct + plan.free_pct + plan.share_pct)
                    op = OP_SHARE;
                else
                    op = OP_UNUSED;
                send_request(op, pick_page(), 1'b0, NO_RESULT);
            end
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (error_count == 0)
            $display("refcounted_page_allocator_top_test: PASS");
        else
            $display("refcounted_page_allocator_top_test: FAIL");
        $finish;
    end

    initial begin
        #8000000;
        $display("refcounted_page_allocator_top_test: FAIL");
        $finish;
    end

endmodule

// ===== refcounted_page_allocator_top.f =====
design/rpa_pkg.sv
design/rpa_ram.sv
design/refcounted_page_allocator_top.sv
bench/refcounted_page_allocator_top_test.sv
